FILE: hdl/sirp_pkg.sv
// ----------------------------------------------------------------------------
// Server-info reply parser package
// Shared types, field codes and status codes for the reply parser.
// ----------------------------------------------------------------------------
package sirp_pkg;

  localparam int unsigned DATA_W        = 8;
  localparam int unsigned CODE_W        = 5;
  localparam int unsigned STATUS_W      = 3;
  localparam int unsigned APP_ID_W      = 16;
  localparam int unsigned POS_W         = 8;
  localparam int unsigned MAX_STR_LEN   = 256;
  localparam int unsigned QUEUE_DEPTH   = 2;

  localparam logic [DATA_W-1:0] HDR_BYTE = 8'hFF;
  localparam logic [POS_W:0]    HDR_LEN  = 9'd4;

  // Field codes.
  localparam logic [CODE_W-1:0] FC_HEADER  = 5'd0;
  localparam logic [CODE_W-1:0] FC_TYPE    = 5'd1;
  localparam logic [CODE_W-1:0] FC_VERSION = 5'd2;
  localparam logic [CODE_W-1:0] FC_STR_A   = 5'd3;
  localparam logic [CODE_W-1:0] FC_STR_D   = 5'd6;
  localparam logic [CODE_W-1:0] FC_APP_LO  = 5'd7;
  localparam logic [CODE_W-1:0] FC_APP_HI  = 5'd8;
  localparam logic [CODE_W-1:0] FC_BYTE_A  = 5'd9;
  localparam logic [CODE_W-1:0] FC_BYTE_G  = 5'd15;
  localparam logic [CODE_W-1:0] FC_GAMEVER = 5'd16;
  localparam logic [CODE_W-1:0] FC_TRAIL   = 5'd17;
  localparam logic [CODE_W-1:0] FC_IGNORED = 5'd18;

  // Packet status codes.
  localparam logic [STATUS_W-1:0] ST_RUN     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DONE    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BADHDR  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TRUNC   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TOOLONG = 3'd4;

  // One classified beat, handed from the front to the back.
  typedef struct packed {
    logic [CODE_W-1:0]   code;
    logic [DATA_W-1:0]   data;
    logic                string_end;
    logic [DATA_W-1:0]   app_lo;
    logic [STATUS_W-1:0] status;
    logic                last;
  } item_t;

endpackage

FILE: hdl/sirp_front.sv
// ----------------------------------------------------------------------------
// Reply parser front end
// Tracks the field position inside the packet and tags each input beat.
// ----------------------------------------------------------------------------
module sirp_front #(
  parameter int unsigned MaxStringLen = sirp_pkg::MAX_STR_LEN
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [sirp_pkg::DATA_W-1:0]  data_byte_i,
  input  logic                         end_of_packet_i,
  input  logic                         q_full_i,
  output logic                         q_push_o,
  output sirp_pkg::item_t              q_item_o
);
  import sirp_pkg::*;

  localparam logic [POS_W:0] MaxLen = (POS_W+1)'(MaxStringLen);

  logic [CODE_W-1:0]   field_q, field_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [DATA_W-1:0]   app_lo_q, app_lo_d;
  logic                drop_q, drop_d;
  logic [STATUS_W-1:0] outcome_q, outcome_d;
  logic [CODE_W-1:0]   code;
  logic                send;
  logic [STATUS_W-1:0] status;
  logic [POS_W:0]      pos_inc;
  logic                fire;

  assign in_ready_o = !q_full_i;
  assign fire       = in_valid_i && in_ready_o;
  assign pos_inc    = {1'b0, pos_q} + 1'b1;

  always_comb begin
    field_d   = field_q;
    pos_d     = pos_q;
    app_lo_d  = app_lo_q;
    drop_d    = drop_q;
    outcome_d = outcome_q;
    code      = field_q;
    send      = 1'b0;
    if (drop_q) begin
      code = FC_IGNORED;
    end else begin
      case (field_q) inside
        FC_HEADER: begin
          if (data_byte_i != HDR_BYTE) begin
            outcome_d = ST_BADHDR;
            drop_d    = 1'b1;
          end else if (pos_inc >= HDR_LEN) begin
            pos_d   = '0;
            field_d = FC_TYPE;
          end else begin
            pos_d = pos_inc[POS_W-1:0];
          end
        end
        [FC_STR_A:FC_STR_D], FC_GAMEVER: begin
          if (data_byte_i == '0) begin
            send    = 1'b1;
            pos_d   = '0;
            field_d = field_q + 1'b1;
            if (field_q == FC_GAMEVER) outcome_d = ST_DONE;
          end else if (pos_inc >= MaxLen) begin
            // No room is left for the terminator.
            outcome_d = ST_TOOLONG;
            drop_d    = 1'b1;
          end else begin
            pos_d = pos_inc[POS_W-1:0];
          end
        end
        FC_APP_LO: begin
          app_lo_d = data_byte_i;
          field_d  = FC_APP_HI;
        end
        FC_APP_HI: begin
          field_d = FC_BYTE_A;
        end
        FC_TRAIL: begin
        end
        FC_TYPE, FC_VERSION, [FC_BYTE_A:FC_BYTE_G]: begin
          field_d = field_q + 1'b1;
        end
        default: begin
          // An index outside the layout behaves as trailing data.
          field_d = FC_TRAIL;
          code    = FC_TRAIL;
        end
      endcase
    end

    status = outcome_d;
    if (end_of_packet_i && status == ST_RUN) status = ST_TRUNC;

    if (end_of_packet_i) begin
      field_d   = FC_HEADER;
      pos_d     = '0;
      app_lo_d  = '0;
      drop_d    = 1'b0;
      outcome_d = ST_RUN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_q   <= FC_HEADER;
      pos_q     <= '0;
      app_lo_q  <= '0;
      drop_q    <= 1'b0;
      outcome_q <= ST_RUN;
    end else if (fire) begin
      field_q   <= field_d;
      pos_q     <= pos_d;
      app_lo_q  <= app_lo_d;
      drop_q    <= drop_d;
      outcome_q <= outcome_d;
    end
  end

  assign q_push_o            = fire;
  assign q_item_o.code       = code;
  assign q_item_o.data       = data_byte_i;
  assign q_item_o.string_end = send;
  assign q_item_o.app_lo     = app_lo_q;
  assign q_item_o.status     = status;
  assign q_item_o.last       = end_of_packet_i;

  a_eop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && end_of_packet_i |=> field_q == FC_HEADER && !drop_q && outcome_q == ST_RUN)
    else $error("state not cleared after packet end");

  a_drop_has_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drop_q |-> outcome_q == ST_BADHDR || outcome_q == ST_TOOLONG)
    else $error("dropping without an error outcome");

  // The header count shares this register and may exceed a short string limit.
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    field_q != FC_HEADER |-> {1'b0, pos_q} < MaxLen)
    else $error("string position reached the maximum length");

  a_hold_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full_i |=> $stable(field_q) && $stable(outcome_q))
    else $error("parser state moved while the queue was full");

endmodule

FILE: hdl/sirp_queue.sv
// ----------------------------------------------------------------------------
// Reply parser beat queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module sirp_queue #(
  parameter int unsigned Depth = sirp_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sirp_pkg::item_t push_item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output sirp_pkg::item_t pop_item_o
);
  import sirp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o     = cnt_q == Full;
  assign empty_o    = cnt_q == '0;
  assign pop_item_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

FILE: hdl/sirp_back.sv
// ----------------------------------------------------------------------------
// Reply parser back end
// Drains the queue into the output register and assembles the app id.
// ----------------------------------------------------------------------------
module sirp_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_empty_i,
  input  sirp_pkg::item_t               q_item_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sirp_pkg::CODE_W-1:0]   field_code_o,
  output logic [sirp_pkg::DATA_W-1:0]   value_o,
  output logic                          string_end_o,
  output logic [sirp_pkg::APP_ID_W-1:0] app_id_o,
  output logic [sirp_pkg::STATUS_W-1:0] status_o,
  output logic                          last_o
);
  import sirp_pkg::*;

  logic                valid_q;
  logic [CODE_W-1:0]   code_q;
  logic [DATA_W-1:0]   data_q;
  logic                send_q;
  logic [APP_ID_W-1:0] app_q, app_d;
  logic [STATUS_W-1:0] status_q;
  logic                last_q;

  assign q_pop_o = !q_empty_i && (!valid_q || out_ready_i);

  // The app id is only shown on its high byte.
  assign app_d = (q_item_i.code == FC_APP_HI) ? {q_item_i.data, q_item_i.app_lo} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (q_pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      code_q   <= q_item_i.code;
      data_q   <= q_item_i.data;
      send_q   <= q_item_i.string_end;
      app_q    <= app_d;
      status_q <= q_item_i.status;
      last_q   <= q_item_i.last;
    end
  end

  assign out_valid_o  = valid_q;
  assign field_code_o = code_q;
  assign value_o      = data_q;
  assign string_end_o = send_q;
  assign app_id_o     = app_q;
  assign status_o     = status_q;
  assign last_o       = last_q;

endmodule

FILE: hdl/server_info_reply_parser_unit.sv
// ----------------------------------------------------------------------------
// Server-info reply parser
// Tags each byte of a server-info reply with its field and packet status.
// ----------------------------------------------------------------------------
// The parser takes one packet byte per beat and returns one tagged beat for
// each, in order. It sustains one byte per clock cycle; the field tracker in
// the front end updates its state as each byte is taken, which sets that
// rate. Each byte is tagged and written into a two-entry queue at the edge
// that accepts it, and the back end then moves it into the output register
// once that register is free or being taken. The queue lets the input keep
// flowing while a result waits on the output side; once both queue entries
// and the output register hold beats, the input stalls until the output is
// taken. After a beat with the last flag the next byte starts a new packet.
module server_info_reply_parser_unit #(
  parameter int unsigned MaxStringLen = sirp_pkg::MAX_STR_LEN
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [sirp_pkg::DATA_W-1:0]   data_byte_i,
  input  logic                          end_of_packet_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sirp_pkg::CODE_W-1:0]   field_code_o,
  output logic [sirp_pkg::DATA_W-1:0]   value_o,
  output logic                          string_end_o,
  output logic [sirp_pkg::APP_ID_W-1:0] app_id_o,
  output logic [sirp_pkg::STATUS_W-1:0] status_o,
  output logic                          last_o
);
  import sirp_pkg::*;

  logic  q_push, q_pop, q_full, q_empty;
  item_t push_item, pop_item;

  sirp_front #(
    .MaxStringLen(MaxStringLen)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .end_of_packet_i(end_of_packet_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_item_o       (push_item)
  );

  sirp_queue #(
    .Depth(QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_item_i(push_item),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .pop_item_o (pop_item)
  );

  sirp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_item_i    (pop_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .field_code_o(field_code_o),
    .value_o     (value_o),
    .string_end_o(string_end_o),
    .app_id_o    (app_id_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

endmodule
